// ===== src/mfe_pkg.sv =====
// Shared types, codes and the CRC fold for the MAVLink v2 frame encoder.
`timescale 1ns / 1ps

package mfe_pkg;

    localparam logic [7:0] FRAME_MAGIC = 8'hFD;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam int unsigned HDR_LAST = 9;
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    // Input command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA = 1'b1;

    // Configuration register indexes
    localparam logic CFG_SYSTEM_IDENT = 1'b0;
    localparam logic CFG_COMPONENT_IDENT = 1'b1;

    typedef enum logic [1:0] {
        OP_START = 2'b01,
        OP_DATA  = 2'b10
    } op_kind_t;

    // One unit of work handed from the front to the back.
    typedef struct packed {
        op_kind_t    kind;
        logic        finish;
        logic [23:0] msg_ident;
        logic [7:0]  extra;
        logic [7:0]  length;
        logic [7:0]  seq;
        logic [7:0]  body;
    } op_t;

    // X.25 / MCRF4XX update with one byte.
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] t;
        t = b ^ crc[7:0];
        t = t ^ {t[3:0], 4'd0};
        return {8'd0, crc[15:8]} ^ {t, 8'd0} ^ {5'd0, t, 3'd0} ^ {12'd0, t[7:4]};
    endfunction

endpackage

// ===== src/mavlink2_frame_encoder.sv =====
// Top level of the MAVLink v2 frame encoder: config registers and the front/queue/back chain.
// With the queue empty and the back idle, an accepted data item goes through the op
// queue and the output register to out_valid. Throughput: one data item per cycle when
// out_stall is low; a start item makes 10 bytes (12 at length zero), a closing data item 3.
// The op queue lets the input keep running during header and CRC bursts until it fills.
// Reset (rst_n, async, low) clears sequence number, open frame, ids and queue.
`timescale 1ns / 1ps

module mavlink2_frame_encoder
    import mfe_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [23:0] msg_ident,
    input  logic [7:0]  extra_seed,
    input  logic [7:0]  body_length,
    input  logic [7:0]  body_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        frame_end
);

    logic [7:0] system_ident_reg;
    logic [7:0] component_ident_reg;
    logic       push;
    logic       pop;
    logic       q_full;
    logic       q_empty;
    op_t        push_op;
    op_t        head_op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            system_ident_reg <= 8'd0;
            component_ident_reg <= 8'd0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_SYSTEM_IDENT: system_ident_reg <= cfg_data;
                CFG_COMPONENT_IDENT: component_ident_reg <= cfg_data;
                default: system_ident_reg <= system_ident_reg;
            endcase
        end
    end

    mfe_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .command     (command),
        .msg_ident   (msg_ident),
        .extra_seed  (extra_seed),
        .body_length (body_length),
        .body_byte   (body_byte),
        .q_full      (q_full),
        .in_stall    (in_stall),
        .push        (push),
        .push_op     (push_op)
    );

    mfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head_op (head_op),
        .full    (q_full),
        .empty   (q_empty)
    );

    mfe_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .system_ident    (system_ident_reg),
        .component_ident (component_ident_reg),
        .head_op         (head_op),
        .q_empty         (q_empty),
        .pop             (pop),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .out_byte        (out_byte),
        .frame_end       (frame_end)
    );

endmodule

// ===== src/mfe_front.sv =====
// Front end: accepts items, tracks the open frame and issues work ops.
`timescale 1ns / 1ps

module mfe_front
    import mfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        command,
    input  logic [23:0] msg_ident,
    input  logic [7:0]  extra_seed,
    input  logic [7:0]  body_length,
    input  logic [7:0]  body_byte,
    input  logic        q_full,
    output logic        in_stall,
    output logic        push,
    output op_t         push_op
);

    logic       frame_open_reg, frame_open_next;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic [7:0] seq_reg, seq_next;
    logic [7:0] held_extra_reg, held_extra_next;
    logic       accept;

    assign in_stall = q_full;
    assign accept = in_valid && !q_full;

    always_comb
    begin
        frame_open_next = frame_open_reg;
        bytes_left_next = bytes_left_reg;
        seq_next = seq_reg;
        held_extra_next = held_extra_reg;
        push = 1'b0;
        push_op.kind = OP_DATA;
        push_op.finish = 1'b0;
        push_op.msg_ident = msg_ident;
        push_op.extra = held_extra_reg;
        push_op.length = body_length;
        push_op.seq = seq_reg;
        push_op.body = body_byte;
        if (accept)
        begin
            if (command == CMD_START)
            begin
                // a start abandons whatever frame is open
                push = 1'b1;
                push_op.kind = OP_START;
                push_op.finish = (body_length == 8'd0);
                push_op.extra = extra_seed;
                seq_next = seq_reg + 8'd1;
                held_extra_next = extra_seed;
                bytes_left_next = body_length;
                frame_open_next = (body_length != 8'd0);
            end
            else if (frame_open_reg)
            begin
                push = 1'b1;
                push_op.finish = (bytes_left_reg == 8'd1);
                bytes_left_next = bytes_left_reg - 8'd1;
                frame_open_next = (bytes_left_reg != 8'd1);
            end
            // drop data beats with no open frame
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg <= 1'b0;
            bytes_left_reg <= 8'd0;
            seq_reg <= 8'd0;
            held_extra_reg <= 8'd0;
        end
        else
        begin
            frame_open_reg <= frame_open_next;
            bytes_left_reg <= bytes_left_next;
            seq_reg <= seq_next;
            held_extra_reg <= held_extra_next;
        end
    end

    a_open_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        frame_open_reg |-> bytes_left_reg != 8'd0)
        else $error("frame open with no payload bytes left");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !push)
        else $error("push into a full queue");

endmodule

// ===== src/mfe_queue.sv =====
// Short FIFO of work ops between the front and the back.
`timescale 1ns / 1ps

module mfe_queue
    import mfe_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_op,
    input  logic pop,
    output op_t  head_op,
    output logic full,
    output logic empty
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    op_t              slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full = (count_reg == DEPTH_CNT);
    assign empty = (count_reg == '0);
    assign head_op = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        // wrap at the last slot
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from an empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("queue count beyond depth");

endmodule

// ===== src/mfe_back.sv =====
// Back end: turns work ops into packet bytes and keeps the running CRC.
`timescale 1ns / 1ps

module mfe_back
    import mfe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] system_ident,
    input  logic [7:0] component_ident,
    input  op_t        head_op,
    input  logic       q_empty,
    output logic       pop,
    input  logic       out_stall,
    output logic       out_valid,
    output logic [7:0] out_byte,
    output logic       frame_end
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_HDR    = 4'b0010,
        ST_CRC_LO = 4'b0100,
        ST_CRC_HI = 4'b1000
    } state_t;

    state_t      state_reg, state_next;
    logic [3:0]  idx_reg, idx_next;
    op_t         cur_reg, cur_next;
    logic [15:0] crc_reg, crc_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic        frame_end_reg, frame_end_next;
    logic        advance;
    logic [7:0]  hdr_byte;
    logic [15:0] crc_tail;

    assign advance = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_byte = out_byte_reg;
    assign frame_end = frame_end_reg;
    assign crc_tail = crc_fold(crc_reg, cur_reg.extra);

    always_comb
    begin
        case (idx_reg)
            4'd1: hdr_byte = cur_reg.length;
            4'd4: hdr_byte = cur_reg.seq;
            4'd5: hdr_byte = system_ident;
            4'd6: hdr_byte = component_ident;
            4'd7: hdr_byte = cur_reg.msg_ident[7:0];
            4'd8: hdr_byte = cur_reg.msg_ident[15:8];
            4'd9: hdr_byte = cur_reg.msg_ident[23:16];
            default: hdr_byte = 8'd0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        cur_next = cur_reg;
        crc_next = crc_reg;
        out_valid_next = out_valid_reg;
        out_byte_next = out_byte_reg;
        frame_end_next = frame_end_reg;
        pop = 1'b0;
        if (advance)
        begin
            out_valid_next = 1'b0;
            frame_end_next = 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        pop = 1'b1;
                        cur_next = head_op;
                        out_valid_next = 1'b1;
                        if (head_op.kind == OP_START)
                        begin
                            // magic byte is outside the CRC
                            out_byte_next = FRAME_MAGIC;
                            crc_next = CRC_INIT;
                            idx_next = 4'd1;
                            state_next = ST_HDR;
                        end
                        else
                        begin
                            out_byte_next = head_op.body;
                            crc_next = crc_fold(crc_reg, head_op.body);
                            if (head_op.finish)
                                state_next = ST_CRC_LO;
                        end
                    end
                end
                ST_HDR:
                begin
                    out_valid_next = 1'b1;
                    out_byte_next = hdr_byte;
                    crc_next = crc_fold(crc_reg, hdr_byte);
                    idx_next = idx_reg + 4'd1;
                    if (idx_reg == 4'(HDR_LAST))
                        state_next = cur_reg.finish ? ST_CRC_LO : ST_IDLE;
                end
                ST_CRC_LO:
                begin
                    // fold the extra byte, then emit low half
                    out_valid_next = 1'b1;
                    crc_next = crc_tail;
                    out_byte_next = crc_tail[7:0];
                    state_next = ST_CRC_HI;
                end
                ST_CRC_HI:
                begin
                    out_valid_next = 1'b1;
                    out_byte_next = crc_reg[15:8];
                    frame_end_next = 1'b1;
                    state_next = ST_IDLE;
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg <= 4'd0;
            crc_reg <= CRC_INIT;
            out_valid_reg <= 1'b0;
            frame_end_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            crc_reg <= crc_next;
            out_valid_reg <= out_valid_next;
            frame_end_reg <= frame_end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        out_byte_reg <= out_byte_next;
    end

    a_hdr_index: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_HDR |-> idx_reg != 4'd0 && idx_reg <= 4'(HDR_LAST))
        else $error("header index out of range");

    a_crc_lo_then_hi: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CRC_LO && advance |=>
            state_reg == ST_CRC_HI && out_valid_reg && !frame_end_reg)
        else $error("CRC low beat not followed by high half");

    a_end_from_hi: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(frame_end_reg) |-> $past(state_reg) == ST_CRC_HI)
        else $error("frame end outside the CRC high beat");

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the MAVLink v2 frame encoder: directed table, header storm, then random traffic.
`timescale 1ns / 1ps

module tb;
    import mfe_pkg::*;

    typedef struct {
        logic        cmd;
        logic [23:0] ident;
        logic [7:0]  extra;
        logic [7:0]  length;
        logic [7:0]  body;
        int          want_beats;    // -1: predictor only
    } stim_row_t;

    typedef struct {
        logic [7:0] value;
        logic       last;
    } frame_byte_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_write;
    logic        cfg_index;
    logic [7:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        command;
    logic [23:0] msg_ident;
    logic [7:0]  extra_seed;
    logic [7:0]  body_length;
    logic [7:0]  body_byte;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  out_byte;
    logic        frame_end;

    mavlink2_frame_encoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .msg_ident   (msg_ident),
        .extra_seed  (extra_seed),
        .body_length (body_length),
        .body_byte   (body_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .frame_end   (frame_end)
    );

    always #4 clk = ~clk;

    // Encoder state as the testbench sees it
    logic [7:0]  sys_id_m;
    logic [7:0]  comp_id_m;
    logic [7:0]  seq_m;
    logic [7:0]  left_m;
    logic [7:0]  extra_m;
    logic [15:0] crc_m;
    logic        open_m;

    frame_byte_t expected_bytes[$];
    int errors;
    int start_count;
    int item_count;
    int burst_left;

    stim_row_t directed_rows [0:17] = '{
        '{CMD_START, 24'h000000, 8'h00, 8'h00, 8'h00, 12},
        '{CMD_DATA,  24'h000000, 8'h00, 8'h00, 8'hFF, 0},   // no frame open
        '{CMD_START, 24'hFFFFFF, 8'hFF, 8'h01, 8'h00, 10},
        '{CMD_DATA,  24'h000000, 8'h00, 8'h00, 8'hFF, 3},
        '{CMD_DATA,  24'hFFFFFF, 8'hFF, 8'hFF, 8'h00, 0},   // ignored, start fields full
        '{CMD_START, 24'h123456, 8'h32, 8'h03, 8'h00, 10},
        '{CMD_DATA,  24'h000000, 8'h00, 8'h00, 8'h00, 1},
        '{CMD_START, 24'h0000FF, 8'h7F, 8'h02, 8'h00, 10},  // abandons the open frame
        '{CMD_DATA,  24'h000000, 8'h00, 8'h00, 8'hA5, 1},
        '{CMD_DATA,  24'h000000, 8'h00, 8'h00, 8'h5A, 3},
        '{CMD_START, 24'hABCDEF, 8'h80, 8'hFF, 8'h00, 10},
        '{CMD_DATA,  24'h000000, 8'h00, 8'h00, 8'h01, -1},
        '{CMD_DATA,  24'h000000, 8'h00, 8'h00, 8'hFE, -1},
        '{CMD_START, 24'h800000, 8'h01, 8'h00, 8'h00, 12},  // abandon into a zero-length frame
        '{CMD_START, 24'h00FF00, 8'hFE, 8'h80, 8'h00, 10},
        '{CMD_START, 24'h7FFFFF, 8'h00, 8'h01, 8'h00, 10},
        '{CMD_DATA,  24'h000000, 8'h00, 8'h00, 8'h80, 3},
        '{CMD_DATA,  24'h000000, 8'h00, 8'h00, 8'h7F, 0}
    };

    task automatic flag_mismatch(input string what);
        if (errors < 40)
            $display("MISMATCH at %0t: %s", $time, what);
        errors++;
    endtask

    // Bitwise reflected form of the X.25 CRC, polynomial 0x8408
    function automatic logic [15:0] crc_x25_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'd0, b};
        for (int i = 0; i < 8; i++)
            c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
        return c;
    endfunction

    task automatic push_byte(input logic [7:0] value, input logic last);
        frame_byte_t fb;
        fb.value = value;
        fb.last = last;
        expected_bytes.push_back(fb);
    endtask

    task automatic close_frame();
        crc_m = crc_x25_step(crc_m, extra_m);
        push_byte(crc_m[7:0], 1'b0);
        push_byte(crc_m[15:8], 1'b1);
        open_m = 1'b0;
        left_m = 8'd0;
    endtask

    task automatic encode_item(input stim_row_t it, output int beats);
        logic [79:0] hdr;
        beats = 0;
        if (it.cmd == CMD_START) begin
            hdr = {it.ident[23:16], it.ident[15:8], it.ident[7:0], comp_id_m, sys_id_m,
                   seq_m, 8'd0, 8'd0, it.length, FRAME_MAGIC};
            extra_m = it.extra;
            left_m = it.length;
            seq_m = seq_m + 8'd1;
            crc_m = CRC_INIT;
            for (int i = 0; i < 10; i++)
            begin
                // magic byte stays out of the CRC
                if (i != 0)
                    crc_m = crc_x25_step(crc_m, hdr[8*i +: 8]);
                push_byte(hdr[8*i +: 8], 1'b0);
            end
            open_m = 1'b1;
            beats = 10;
            start_count++;
            if (left_m == 8'd0)
            begin
                close_frame();
                beats = 12;
            end
        end
        else if (open_m)
        begin
            crc_m = crc_x25_step(crc_m, it.body);
            push_byte(it.body, 1'b0);
            left_m = left_m - 8'd1;
            beats = 1;
            if (left_m == 8'd0)
            begin
                close_frame();
                beats = 3;
            end
        end
    endtask

    // Offer one beat in sender bursts; call only at a rising edge.
    task automatic send_item(input stim_row_t it, output int beats);
        int gap;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                burst_left = $urandom_range(30, 80);
                gap = 0;
            end
            else
            begin
                burst_left = $urandom_range(1, 12);
                gap = $urandom_range(0, 6);
            end
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        command <= it.cmd;
        msg_ident <= it.ident;
        extra_seed <= it.extra;
        body_length <= it.length;
        body_byte <= it.body;
        do
            @(posedge clk);
        while (in_stall);
        encode_item(it, beats);
        if (beats > 0)
            item_count++;
    endtask

    // Stop offering and wait until every expected byte is out.
    task automatic drain();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        burst_left = 0;
        while (expected_bytes.size() > 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        // ignored beats may still be in flight
        repeat (8) @(posedge clk);
    endtask

    task automatic write_ids(input logic [7:0] sys_v, input logic [7:0] comp_v);
        cfg_write <= 1'b1;
        cfg_index <= CFG_SYSTEM_IDENT;
        cfg_data <= sys_v;
        @(posedge clk);
        cfg_index <= CFG_COMPONENT_IDENT;
        cfg_data <= comp_v;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        sys_id_m = sys_v;
        comp_id_m = comp_v;
    endtask

    task automatic random_traffic(input int stop_at);
        stim_row_t it;
        int beats;
        int pick;
        int roll;
        int len;
        int sent;
        while (item_count < stop_at)
        begin
            pick = $urandom_range(0, 99);
            it.cmd = CMD_START;
            it.ident = 24'($urandom_range(0, 32'hFF_FFFF));
            it.extra = 8'($urandom_range(0, 255));
            it.length = 8'($urandom_range(0, 255));
            it.body = 8'($urandom_range(0, 255));
            it.want_beats = -1;
            if (pick < 10)
            begin
                // noise: any command, any field
                it.cmd = 1'($urandom_range(0, 1));
                send_item(it, beats);
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 25)
                    len = 0;
                else if (roll < 60)
                    len = $urandom_range(1, 4);
                else if (roll < 97)
                    len = $urandom_range(5, 24);
                else
                    len = $urandom_range(128, 255);
                it.length = 8'(len);
                send_item(it, beats);
                // cut some frames short so the next start abandons them
                sent = (pick < 20 && len > 1) ? $urandom_range(1, len - 1) : len;
                it.cmd = CMD_DATA;
                for (int i = 0; i < sent; i++)
                begin
                    it.body = 8'($urandom_range(0, 255));
                    send_item(it, beats);
                end
            end
        end
    endtask

    always @(posedge clk)
    begin : check_output
        frame_byte_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_bytes.size() == 0)
                flag_mismatch($sformatf("unexpected byte %02h end %b", out_byte, frame_end));
            else
            begin
                want = expected_bytes.pop_front();
                if (out_byte !== want.value)
                    flag_mismatch($sformatf("out_byte %02h, want %02h", out_byte, want.value));
                if (frame_end !== want.last)
                    flag_mismatch($sformatf("frame_end %b, want %b", frame_end, want.last));
            end
        end
    end

    initial
    begin : receiver
        int span;
        int mode;
        int segment;
        segment = 0;
        out_stall <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            mode = $urandom_range(0, 9);
            span = $urandom_range(10, 60);
            if (segment == 12 || mode == 0)
            begin
                // long hold-off: let the block fill up and stall its input
                out_stall <= 1'b1;
                repeat ($urandom_range(60, 120)) @(posedge clk);
            end
            else if (mode < 4)
            begin
                out_stall <= 1'b0;
                repeat (span) @(posedge clk);
            end
            else
            begin
                repeat (span)
                begin
                    out_stall <= ($urandom_range(0, 2) == 0);
                    @(posedge clk);
                end
            end
            segment++;
        end
    end

    initial
    begin : watchdog
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : main
        stim_row_t it;
        int beats;
        rst_n <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= CFG_SYSTEM_IDENT;
        cfg_data <= 8'd0;
        in_valid <= 1'b0;
        command <= CMD_START;
        msg_ident <= 24'd0;
        extra_seed <= 8'd0;
        body_length <= 8'd0;
        body_byte <= 8'd0;
        errors = 0;
        start_count = 0;
        item_count = 0;
        burst_left = 0;
        sys_id_m = 8'd0;
        comp_id_m = 8'd0;
        seq_m = 8'd0;
        left_m = 8'd0;
        extra_m = 8'd0;
        crc_m = CRC_INIT;
        open_m = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            send_item(directed_rows[r], beats);
            if (directed_rows[r].want_beats >= 0 && beats != directed_rows[r].want_beats)
                flag_mismatch($sformatf("row %0d gives %0d bytes, want %0d",
                                        r, beats, directed_rows[r].want_beats));
        end
        drain();

        // Header storm: enough frames for the sequence number to wrap
        write_ids(8'hFF, 8'hFF);
        while (start_count < 260)
        begin
            it.cmd = CMD_START;
            it.ident = 24'($urandom_range(0, 32'hFF_FFFF));
            it.extra = 8'($urandom_range(0, 255));
            it.length = ($urandom_range(0, 4) == 0) ? 8'd1 : 8'd0;
            it.body = 8'd0;
            it.want_beats = -1;
            send_item(it, beats);
            if (it.length != 8'd0)
            begin
                it.cmd = CMD_DATA;
                it.body = 8'($urandom_range(0, 255));
                send_item(it, beats);
            end
        end
        drain();

        write_ids(8'h00, 8'hFF);
        random_traffic(item_count + 30);
        drain();
        write_ids(8'hFF, 8'h00);
        random_traffic(item_count + 30);
        drain();
        write_ids(8'($urandom_range(1, 254)), 8'($urandom_range(1, 254)));
        random_traffic(item_count + 30);
        drain();

        if (expected_bytes.size() != 0)
            flag_mismatch($sformatf("%0d expected bytes never came", expected_bytes.size()));
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
src/mfe_pkg.sv
src/mfe_front.sv
src/mfe_queue.sv
src/mfe_back.sv
src/mavlink2_frame_encoder.sv
sim/tb.sv
